// ===== rtl/swcc_pkg.sv =====
// Shared types, constants and a helper function for the sliding-window code coverage block.
package swcc_pkg;

    // Configuration port geometry and register map.
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'b0;

    // Fixed field widths.
    localparam int WL_W      = 4;
    localparam int MISSING_W = 11;

    localparam logic [WL_W-1:0] WL_RESET = 4'd1;

    // Control flags of one work record passed from the front end to the back end.
    typedef struct packed {
        logic start;   // clear the window state and coverage map first
        logic mark;    // window is full, so the code marks the map
    } swcc_ctl_t;

    // One result word.
    typedef struct packed {
        logic                 all_codes_seen;
        logic [MISSING_W-1:0] codes_missing;
        logic                 window_full;
    } swcc_result_t;

    // Clamp the programmed window length into 1..max_len.
    function automatic logic [WL_W-1:0] eff_len(input logic [WL_W-1:0] wl, input int max_len);
        logic [WL_W-1:0] k;
        k = wl;
        if (k == '0)
        begin
            k = WL_W'(1);
        end
        else if (int'(k) > max_len)
        begin
            k = WL_W'(max_len);
        end
        return k;
    endfunction

endpackage

// ===== rtl/swcc_fifo.sv =====
// Small register-based queue used between the front end, the back end and the result port.
module swcc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] data_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == (PTR_W+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = data_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + (PTR_W+1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - (PTR_W+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            data_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== rtl/swcc_front.sv =====
// Front end: takes stream bits, keeps the shift window and bit count, and forms work records.
module swcc_front #(
    parameter int MAX_WINDOW = 10
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [swcc_pkg::WL_W-1:0] k,
    input  logic                     accept,
    input  logic                     code_bit,
    input  logic                     start_of_string,
    output logic                     work_push,
    output swcc_pkg::swcc_ctl_t      work_ctl,
    output logic [MAX_WINDOW-1:0]    work_code
);
    import swcc_pkg::*;

    localparam int BR_W = $clog2(MAX_WINDOW + 1);

    logic [MAX_WINDOW-1:0] window_reg, window_next;
    logic [BR_W-1:0]       bits_reg, bits_next;
    logic [MAX_WINDOW-1:0] window_base;
    logic [MAX_WINDOW:0]   shifted;
    logic [BR_W-1:0]       bits_base;
    logic [MAX_WINDOW-1:0] code_mask;
    logic                  full_now;

    always_comb
    begin
        window_base = start_of_string ? '0 : window_reg;
        bits_base   = start_of_string ? '0 : bits_reg;
        shifted     = {window_base, code_bit};
        window_next = shifted[MAX_WINDOW-1:0];
        bits_next   = (int'(bits_base) < MAX_WINDOW) ? bits_base + BR_W'(1) : bits_base;
        full_now    = (int'(bits_next) >= int'(k));
        for (int i = 0; i < MAX_WINDOW; i++)
        begin
            code_mask[i] = (i < int'(k));
        end
    end

    assign work_push      = accept;
    assign work_ctl.start = start_of_string;
    assign work_ctl.mark  = full_now;
    assign work_code      = window_next & code_mask;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
            bits_reg   <= '0;
        end
        else if (accept)
        begin
            window_reg <= window_next;
            bits_reg   <= bits_next;
        end
    end

endmodule

// ===== rtl/swcc_back.sv =====
// Back end: read-modify-write of the coverage bitmap and the missing-code count.
module swcc_back #(
    parameter int MAX_WINDOW = 10
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [swcc_pkg::WL_W-1:0] k,
    input  logic                      work_valid,
    input  swcc_pkg::swcc_ctl_t       work_ctl,
    input  logic [MAX_WINDOW-1:0]     work_code,
    output logic                      work_pop,
    input  logic                      res_full,
    output logic                      res_push,
    output swcc_pkg::swcc_result_t    res_data
);
    import swcc_pkg::*;

    // The bitmap is kept as rows of bits; each row has a valid flag so a start clears it at once.
    localparam int CODE_W = (MAX_WINDOW < 2) ? 2 : MAX_WINDOW;
    localparam int ROW_W  = CODE_W / 2;
    localparam int COL_W  = CODE_W - ROW_W;
    localparam int ROWS   = 1 << ROW_W;
    localparam int COLS   = 1 << COL_W;
    localparam int CNT_W  = MAX_WINDOW + 1;

    logic [COLS-1:0]  seen_mem [ROWS];
    logic [COLS-1:0]  rd_data_reg;
    logic [COLS-1:0]  fwd_data_reg;
    logic             fwd_reg;
    logic [ROWS-1:0]  row_valid_reg, row_valid_next;
    logic [CNT_W-1:0] missing_reg, missing_next;
    logic             b_valid_reg;
    swcc_ctl_t        b_ctl_reg;
    logic [ROW_W-1:0] b_row_reg;
    logic [COL_W-1:0] b_col_reg;

    logic [CODE_W-1:0] code_ext;
    logic [ROW_W-1:0]  head_row;
    logic [COL_W-1:0]  head_col;
    logic              b_fire;
    logic              advance;
    logic [COLS-1:0]   row_data;
    logic [COLS-1:0]   row_new;
    logic              seen;
    logic [CNT_W-1:0]  missing_base;
    logic              decrement;

    assign code_ext = CODE_W'(work_code);
    assign head_row = code_ext[CODE_W-1:COL_W];
    assign head_col = code_ext[COL_W-1:0];
    assign b_fire   = b_valid_reg && !res_full;
    assign advance  = work_valid && (!b_valid_reg || b_fire);
    assign work_pop = advance;

    always_comb
    begin
        row_data = '0;
        if (!b_ctl_reg.start)
        begin
            if (fwd_reg)
            begin
                row_data = fwd_data_reg;
            end
            else if (row_valid_reg[b_row_reg])
            begin
                row_data = rd_data_reg;
            end
        end
        seen    = row_data[b_col_reg];
        row_new = row_data | (COLS'(1) << b_col_reg);

        missing_base = b_ctl_reg.start ? (CNT_W'(1) << k) : missing_reg;
        decrement    = b_ctl_reg.mark && !seen && (missing_base != '0);
        missing_next = decrement ? missing_base - CNT_W'(1) : missing_base;

        row_valid_next = b_ctl_reg.start ? '0 : row_valid_reg;
        if (b_ctl_reg.mark)
        begin
            row_valid_next[b_row_reg] = 1'b1;
        end
    end

    assign res_push                = b_fire;
    assign res_data.all_codes_seen = (missing_next == '0);
    assign res_data.codes_missing  = MISSING_W'(missing_next);
    assign res_data.window_full    = b_ctl_reg.mark;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg   <= 1'b0;
            fwd_reg       <= 1'b0;
            row_valid_reg <= '0;
            missing_reg   <= CNT_W'(2);
        end
        else
        begin
            if (advance)
            begin
                b_valid_reg <= 1'b1;
                fwd_reg     <= b_fire && b_ctl_reg.mark && (head_row == b_row_reg);
            end
            else if (b_fire)
            begin
                b_valid_reg <= 1'b0;
            end
            if (b_fire)
            begin
                row_valid_reg <= row_valid_next;
                missing_reg   <= missing_next;
            end
        end
    end

    // Work record and forwarded row are payload.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            b_ctl_reg    <= work_ctl;
            b_row_reg    <= head_row;
            b_col_reg    <= head_col;
            fwd_data_reg <= row_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_fire && b_ctl_reg.mark)
        begin
            seen_mem[b_row_reg] <= row_new;
        end
        if (advance)
        begin
            rd_data_reg <= seen_mem[head_row];
        end
    end

endmodule

// ===== rtl/sliding_window_code_coverage_top.sv =====
// Top level of the sliding-window code coverage block with its configuration register.
//
// The input side behaves like a queue: a word (code_bit, start_of_string) is taken at a
// rising edge with push high and full low. The result side behaves like a queue too:
// while empty is low the oldest result word is on all_codes_seen, codes_missing and
// window_full, and pop with empty low takes it. Every accepted word gives one result word.
// Throughput is one word per clock cycle while the result queue has room. The rate is set
// by the coverage bitmap: one row per cycle, read for every word and written for marking
// words, with the row just written forwarded to the next word in the same row so that
// repeated codes do not wait. A word goes from the front end into the work queue, then
// into the bitmap stage and then the result queue. When the receiver stops popping, the
// result queue fills, the bitmap stage holds, the work queue fills and then full rises;
// nothing is lost or repeated. Reset clears the window, the bit count and every bitmap
// row flag, sets window_length to one and the missing count to two. A start word does
// the same clearing but sets the missing count to two to the power of the clamped
// window_length in force, before its own bit is taken. window_length sits at byte address
// 0 of the APB port; the user must write it only when idle; the block does not enforce it.
module sliding_window_code_coverage_top #(
    parameter int MAX_WINDOW  = 10,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Input queue side
    input  logic                                push,
    output logic                                full,
    input  logic                                code_bit,
    input  logic                                start_of_string,
    // Result queue side
    output logic                                empty,
    input  logic                                pop,
    output logic                                all_codes_seen,
    output logic [swcc_pkg::MISSING_W-1:0]      codes_missing,
    output logic                                window_full,
    // Configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [swcc_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [swcc_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [swcc_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import swcc_pkg::*;

    localparam int WORK_W = $bits(swcc_ctl_t) + MAX_WINDOW;
    localparam int RES_W  = $bits(swcc_result_t);

    logic [WL_W-1:0]      window_length_reg;
    logic [WL_W-1:0]      k;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 cfg_write;

    logic                  work_full;
    logic                  accept;
    logic                  work_push;
    swcc_ctl_t             front_ctl;
    logic [MAX_WINDOW-1:0] front_code;
    logic [WORK_W-1:0]     wq_wdata, wq_rdata;
    logic                  wq_empty;
    logic                  work_pop;
    swcc_ctl_t             head_ctl;
    logic [MAX_WINDOW-1:0] head_code;

    logic                  res_full;
    logic                  res_push;
    swcc_result_t          res_in;
    logic [RES_W-1:0]      rq_rdata;
    swcc_result_t          res_out;

    // The register index is the word address; the two byte-offset bits are ignored.
    assign reg_idx   = paddr[APB_ADDR_W-1:2];
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (reg_idx == REG_WINDOW_LENGTH);
    assign prdata    = (reg_idx == REG_WINDOW_LENGTH) ? APB_DATA_W'(window_length_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg <= WL_RESET;
        end
        else if (cfg_write)
        begin
            window_length_reg <= pwdata[WL_W-1:0];
        end
    end

    // Out-of-range lengths are clamped once here for both ends.
    assign k = eff_len(window_length_reg, MAX_WINDOW);

    assign full   = work_full;
    assign accept = push && !work_full;

    swcc_front #(
        .MAX_WINDOW(MAX_WINDOW)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .k               (k),
        .accept          (accept),
        .code_bit        (code_bit),
        .start_of_string (start_of_string),
        .work_push       (work_push),
        .work_ctl        (front_ctl),
        .work_code       (front_code)
    );

    assign wq_wdata = {front_ctl, front_code};

    swcc_fifo #(
        .WIDTH (WORK_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_work_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (work_push),
        .wdata (wq_wdata),
        .full  (work_full),
        .pop   (work_pop),
        .rdata (wq_rdata),
        .empty (wq_empty)
    );

    assign head_ctl  = swcc_ctl_t'(wq_rdata[WORK_W-1:MAX_WINDOW]);
    assign head_code = wq_rdata[MAX_WINDOW-1:0];

    swcc_back #(
        .MAX_WINDOW(MAX_WINDOW)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .k          (k),
        .work_valid (!wq_empty),
        .work_ctl   (head_ctl),
        .work_code  (head_code),
        .work_pop   (work_pop),
        .res_full   (res_full),
        .res_push   (res_push),
        .res_data   (res_in)
    );

    swcc_fifo #(
        .WIDTH (RES_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_in),
        .full  (res_full),
        .pop   (pop),
        .rdata (rq_rdata),
        .empty (empty)
    );

    assign res_out        = swcc_result_t'(rq_rdata);
    assign all_codes_seen = res_out.all_codes_seen;
    assign codes_missing  = res_out.codes_missing;
    assign window_full    = res_out.window_full;

endmodule

// ===== rtl/swcc_checker.sv =====
// Port-level checker for the sliding-window code coverage block, bound to the top level.
module swcc_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           push,
    input logic                           full,
    input logic                           empty,
    input logic                           pop,
    input logic                           all_codes_seen,
    input logic [swcc_pkg::MISSING_W-1:0] codes_missing,
    input logic                           window_full
);
    import swcc_pkg::*;

    // Once reset has been held over a full cycle both queues read as drained.
    assert property (@(posedge clk) (!rst_n && $past(!rst_n)) |-> (empty && !full))
        else $error("queues not drained during reset");

    // While a result word waits, the all-seen flag and the missing count agree.
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (all_codes_seen == (codes_missing == '0)))
        else $error("all_codes_seen disagrees with codes_missing");

    // The missing count never exceeds the size of the largest code space.
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (codes_missing <= MISSING_W'(1024)))
        else $error("codes_missing out of range");

    // A result word that is not taken stays on the ports.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(codes_missing) && $stable(all_codes_seen)
                              && $stable(window_full)))
        else $error("waiting result word changed");

endmodule

bind sliding_window_code_coverage_top swcc_checker u_swcc_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .empty          (empty),
    .pop            (pop),
    .all_codes_seen (all_codes_seen),
    .codes_missing  (codes_missing),
    .window_full    (window_full)
);
